// ===== hdl/gbi_pkg.sv =====
// Shared types and constants for the grid bilinear interpolator.
package gbi_pkg;

    localparam int COORD_W  = 9;
    localparam int HEIGHT_W = 10;
    localparam int RESULT_W = 17;
    localparam int FRAC_W   = 4;
    localparam int HUNDRED  = 100;
    localparam int EXTENT_RESET = 320;

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_OFF_LATTICE = 2'd1,
        STATUS_BEYOND      = 2'd2
    } status_t;

    typedef struct packed {
        status_t                status;
        logic [FRAC_W-1:0]      frac_row;
        logic [FRAC_W-1:0]      frac_col;
        logic [HEIGHT_W-1:0]    h_a;
        logic [HEIGHT_W-1:0]    h_b;
        logic [HEIGHT_W-1:0]    h_c;
        logic [HEIGHT_W-1:0]    h_d;
    } entry_t;

endpackage

// ===== hdl/gbi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gbi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/gbi_front.sv =====
// Front end: request intake, lattice decode, classification and banked control-height store.
module gbi_front #(
    parameter int GRID_MAX = 320,
    parameter int SPACING  = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            action,
    input  logic [gbi_pkg::COORD_W-1:0]     row,
    input  logic [gbi_pkg::COORD_W-1:0]     col,
    input  logic [gbi_pkg::HEIGHT_W-1:0]    height,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gbi_pkg::COORD_W-1:0]     cfg_data,
    output logic [1:0]                      inflight,
    output logic                            push,
    output gbi_pkg::entry_t                 push_entry
);

    localparam int SIDE       = GRID_MAX / SPACING + 1;
    localparam int HALF       = (SIDE + 1) / 2;
    localparam int BANK_DEPTH = HALF * HALF;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int ADDR_W     = 2 * gbi_pkg::COORD_W + 2;
    localparam int EXT_W      = gbi_pkg::COORD_W + 2;
    localparam int SP_W       = $clog2(SPACING + 1);
    localparam int DIV_SHIFT  = 16;
    localparam int DIV_MULT   = ((1 << DIV_SHIFT) + SPACING - 1) / SPACING;
    localparam int MUL_W      = DIV_SHIFT + EXT_W + 1;
    localparam int EXT_RESET  =
        ((GRID_MAX < gbi_pkg::EXTENT_RESET) ? GRID_MAX : gbi_pkg::EXTENT_RESET) / SPACING;
    localparam int BASE_W     = gbi_pkg::COORD_W + SP_W;

    // floor(n / SPACING) by reciprocal multiply, exact for n below 2^EXT_W
    function automatic logic [gbi_pkg::COORD_W-1:0] div_spacing(input logic [EXT_W-1:0] n);
        logic [MUL_W-1:0] prod;
        prod = MUL_W'(n) * MUL_W'(DIV_MULT);
        return prod[DIV_SHIFT +: gbi_pkg::COORD_W];
    endfunction

    // configuration
    logic [gbi_pkg::COORD_W-1:0] ext_q_reg, ext_q_next;
    logic [EXT_W-1:0]            cfg_clamped;

    // stage 1
    logic                           s1_valid_reg, s1_valid_next;
    logic                           s1_action_reg;
    logic [gbi_pkg::COORD_W-1:0]    s1_row_reg, s1_col_reg;
    logic [gbi_pkg::COORD_W-1:0]    s1_qr_reg, s1_qc_reg;
    logic [gbi_pkg::HEIGHT_W-1:0]   s1_height_reg;

    // stage 2 decode
    logic [BASE_W-1:0]              row_rem_wide, col_rem_wide;
    logic [gbi_pkg::FRAC_W-1:0]     frac_row, frac_col;
    logic                           beyond;
    logic                           wr_en;
    logic [gbi_pkg::COORD_W-1:0]    half_row [2];
    logic [gbi_pkg::COORD_W-1:0]    half_col [2];
    logic [ADDR_W-1:0]              bank_addr [2][2];
    logic                           bank_we [2][2];
    logic [gbi_pkg::HEIGHT_W-1:0]   bank_rdata [2][2];

    // stage 2
    logic                           s2_valid_reg, s2_valid_next;
    gbi_pkg::status_t               s2_status_reg, s2_status_next;
    logic                           s2_action_reg;
    logic [gbi_pkg::FRAC_W-1:0]     s2_fr_reg, s2_fc_reg;
    logic                           s2_pr_reg, s2_pc_reg;

    logic                           query_ok;
    logic [gbi_pkg::HEIGHT_W-1:0]   h_a, h_b, h_c, h_d;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if ({2'b00, cfg_data} > EXT_W'(GRID_MAX))
        begin
            cfg_clamped = EXT_W'(GRID_MAX);
        end
        else
        begin
            cfg_clamped = {2'b00, cfg_data};
        end
        ext_q_next = cfg_valid ? div_spacing(cfg_clamped) : ext_q_reg;
    end

    assign s1_valid_next = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_q_reg    <= gbi_pkg::COORD_W'(EXT_RESET);
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            ext_q_reg    <= ext_q_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_next)
        begin
            s1_action_reg <= action;
            s1_row_reg    <= row;
            s1_col_reg    <= col;
            s1_qr_reg     <= div_spacing({2'b00, row});
            s1_qc_reg     <= div_spacing({2'b00, col});
            s1_height_reg <= height;
        end
    end

    // remainders and classification
    always_comb
    begin
        row_rem_wide = BASE_W'(s1_row_reg) - BASE_W'(s1_qr_reg) * BASE_W'(SPACING);
        col_rem_wide = BASE_W'(s1_col_reg) - BASE_W'(s1_qc_reg) * BASE_W'(SPACING);
        frac_row = row_rem_wide[gbi_pkg::FRAC_W-1:0];
        frac_col = col_rem_wide[gbi_pkg::FRAC_W-1:0];

        beyond = (s1_qr_reg > ext_q_reg) || ((s1_qr_reg == ext_q_reg) && (frac_row != '0)) ||
                 (s1_qc_reg > ext_q_reg) || ((s1_qc_reg == ext_q_reg) && (frac_col != '0));

        if (beyond)
        begin
            s2_status_next = gbi_pkg::STATUS_BEYOND;
        end
        else if ((s1_action_reg == gbi_pkg::ACTION_WRITE) &&
                 ((frac_row != '0) || (frac_col != '0)))
        begin
            s2_status_next = gbi_pkg::STATUS_OFF_LATTICE;
        end
        else
        begin
            s2_status_next = gbi_pkg::STATUS_OK;
        end

        wr_en = s1_valid_reg && (s1_action_reg == gbi_pkg::ACTION_WRITE) &&
                (s2_status_next == gbi_pkg::STATUS_OK);
        s2_valid_next = s1_valid_reg;
    end

    // bank of parity p holds lattice row lr0 when lr0 has parity p, else lr0 + 1
    assign half_row[1] = s1_qr_reg >> 1;
    assign half_row[0] = (s1_qr_reg >> 1) + gbi_pkg::COORD_W'(s1_qr_reg[0]);
    assign half_col[1] = s1_qc_reg >> 1;
    assign half_col[0] = (s1_qc_reg >> 1) + gbi_pkg::COORD_W'(s1_qc_reg[0]);

    for (genvar pr = 0; pr < 2; pr++)
    begin : g_bank_row
        for (genvar pc = 0; pc < 2; pc++)
        begin : g_bank_col
            assign bank_addr[pr][pc] = ADDR_W'(half_row[pr]) * ADDR_W'(HALF) +
                                       ADDR_W'(half_col[pc]);
            assign bank_we[pr][pc]   = wr_en && (s1_qr_reg[0] == 1'(pr)) &&
                                       (s1_qc_reg[0] == 1'(pc));

            gbi_ram #(
                .WIDTH (gbi_pkg::HEIGHT_W),
                .DEPTH (BANK_DEPTH)
            ) u_bank (
                .clk   (clk),
                .we    (bank_we[pr][pc]),
                .waddr (bank_addr[pr][pc][BANK_AW-1:0]),
                .wdata (s1_height_reg),
                .raddr (bank_addr[pr][pc][BANK_AW-1:0]),
                .rdata (bank_rdata[pr][pc])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_status_reg <= s2_status_next;
            s2_action_reg <= s1_action_reg;
            s2_fr_reg     <= frac_row;
            s2_fc_reg     <= frac_col;
            s2_pr_reg     <= s1_qr_reg[0];
            s2_pc_reg     <= s1_qc_reg[0];
        end
    end

    // unused neighbors are zeroed so their reads never reach the sum
    always_comb
    begin
        query_ok = (s2_action_reg == gbi_pkg::ACTION_QUERY) &&
                   (s2_status_reg == gbi_pkg::STATUS_OK);
        h_a = query_ok ? bank_rdata[s2_pr_reg][s2_pc_reg] : '0;
        h_b = (query_ok && (s2_fc_reg != '0)) ? bank_rdata[s2_pr_reg][!s2_pc_reg] : '0;
        h_c = (query_ok && (s2_fr_reg != '0)) ? bank_rdata[!s2_pr_reg][s2_pc_reg] : '0;
        h_d = (query_ok && (s2_fr_reg != '0) && (s2_fc_reg != '0)) ?
              bank_rdata[!s2_pr_reg][!s2_pc_reg] : '0;

        push_entry.status   = s2_status_reg;
        push_entry.frac_row = s2_fr_reg;
        push_entry.frac_col = s2_fc_reg;
        push_entry.h_a      = h_a;
        push_entry.h_b      = h_b;
        push_entry.h_c      = h_c;
        push_entry.h_d      = h_d;
    end

    assign push     = s2_valid_reg;
    assign inflight = {1'b0, s1_valid_reg} + {1'b0, s2_valid_reg};

endmodule

// ===== hdl/gbi_fifo.sv =====
// Small register FIFO between the front end and the blend pipeline.
module gbi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int LVL_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic [LVL_W-1:0] level
);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + LVL_W'(push) - LVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = entries_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign level = count_reg;

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != LVL_W'(DEPTH)) || pop)
        else $error("fifo overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("fifo underflow");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("fifo pointers disagree with count");
`endif

endmodule

// ===== hdl/gbi_back.sv =====
// Blend pipeline: bilinear weights, weighted sum and scaling to hundredths.
module gbi_back #(
    parameter int SPACING = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            empty,
    input  gbi_pkg::entry_t                 entry,
    output logic                            pop,
    output logic                            done,
    output logic [gbi_pkg::RESULT_W-1:0]    height_hundredths,
    output gbi_pkg::status_t                status
);

    localparam int SP_W        = $clog2(SPACING + 1);
    localparam int WP_W        = 2 * SP_W;
    localparam int DEN         = SPACING * SPACING;
    localparam int WEIGHT_W    = $clog2(DEN + 1);
    localparam int SUM_W       = gbi_pkg::HEIGHT_W + WEIGHT_W;
    localparam int X_W         = SUM_W + 7;
    localparam int RECIP_SHIFT = X_W + WEIGHT_W;
    localparam int Y_W         = X_W + RECIP_SHIFT;
    localparam logic [63:0] RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);

    logic [SP_W-1:0]                wr0, wr1, wc0, wc1;
    logic [WP_W-1:0]                wprod [4];

    logic                           b1_valid_reg;
    gbi_pkg::status_t               b1_status_reg;
    logic [WEIGHT_W-1:0]            b1_w_reg [4];
    logic [gbi_pkg::HEIGHT_W-1:0]   b1_h_reg [4];

    logic                           b2_valid_reg;
    gbi_pkg::status_t               b2_status_reg;
    logic [SUM_W-1:0]               b2_p_reg [4];
    logic [SUM_W-1:0]               b2_p_next [4];

    logic                           b3_valid_reg;
    gbi_pkg::status_t               b3_status_reg;
    logic [SUM_W-1:0]               b3_sum_reg, b3_sum_next;

    logic                           b4_valid_reg;
    gbi_pkg::status_t               b4_status_reg;
    logic [X_W-1:0]                 b4_x_reg, b4_x_next;

    logic                           b5_valid_reg;
    gbi_pkg::status_t               b5_status_reg;
    logic [Y_W-1:0]                 b5_y_reg, b5_y_next;

    assign pop = !empty;

    always_comb
    begin
        wr1 = SP_W'(entry.frac_row);
        wc1 = SP_W'(entry.frac_col);
        wr0 = SP_W'(SPACING) - wr1;
        wc0 = SP_W'(SPACING) - wc1;
        wprod[0] = WP_W'(wr0) * WP_W'(wc0);
        wprod[1] = WP_W'(wr0) * WP_W'(wc1);
        wprod[2] = WP_W'(wr1) * WP_W'(wc0);
        wprod[3] = WP_W'(wr1) * WP_W'(wc1);

        for (int i = 0; i < 4; i++)
        begin
            b2_p_next[i] = SUM_W'(b1_h_reg[i]) * SUM_W'(b1_w_reg[i]);
        end
        b3_sum_next = b2_p_reg[0] + b2_p_reg[1] + b2_p_reg[2] + b2_p_reg[3];
        b4_x_next   = X_W'(b3_sum_reg) * X_W'(gbi_pkg::HUNDRED) + X_W'(DEN / 2);
        b5_y_next   = Y_W'(b4_x_reg) * Y_W'(RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            b5_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= pop;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
            b5_valid_reg <= b4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_status_reg <= entry.status;
        for (int i = 0; i < 4; i++)
        begin
            b1_w_reg[i] <= wprod[i][WEIGHT_W-1:0];
        end
        b1_h_reg[0] <= entry.h_a;
        b1_h_reg[1] <= entry.h_b;
        b1_h_reg[2] <= entry.h_c;
        b1_h_reg[3] <= entry.h_d;

        b2_status_reg <= b1_status_reg;
        b2_p_reg      <= b2_p_next;

        b3_status_reg <= b2_status_reg;
        b3_sum_reg    <= b3_sum_next;

        b4_status_reg <= b3_status_reg;
        b4_x_reg      <= b4_x_next;

        b5_status_reg <= b4_status_reg;
        b5_y_reg      <= b5_y_next;
    end

    assign done              = b5_valid_reg;
    assign status            = b5_status_reg;
    assign height_hundredths = b5_y_reg[RECIP_SHIFT +: gbi_pkg::RESULT_W];

endmodule

// ===== hdl/grid_bilinear_interpolator_core.sv =====
// Top level of the grid bilinear interpolator.
// One request per clock: a request accepted at a clock edge (start high, busy low)
// produces its single result, with done high for one cycle, after passing
// through two front-end stages (lattice decode, then the banked control-height
// read), one queue slot and five blend stages (weights, products, sum, scale by
// 100, reciprocal divide). Results cannot be held off. The control heights sit in
// four RAM banks split by lattice row and column parity, so all four corners of a
// query are read in the same cycle. The store is not cleared at reset: querying a
// lattice point that was never written gives an arbitrary height. A grid_extent
// write takes effect for the request accepted at the same edge.
module grid_bilinear_interpolator_core #(
    parameter int GRID_MAX = 320,
    parameter int SPACING  = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            action,
    input  logic [gbi_pkg::COORD_W-1:0]     row,
    input  logic [gbi_pkg::COORD_W-1:0]     col,
    input  logic [gbi_pkg::HEIGHT_W-1:0]    height,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gbi_pkg::COORD_W-1:0]     cfg_data,
    output logic                            done,
    output logic [gbi_pkg::RESULT_W-1:0]    height_hundredths,
    output logic [1:0]                      status
);

    localparam int FIFO_DEPTH = 4;
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);
    localparam int LATENCY    = 8;

    logic                   push;
    logic                   pop;
    logic                   fifo_empty;
    logic [LVL_W-1:0]       fifo_level;
    logic [1:0]             inflight;
    gbi_pkg::entry_t        push_entry;
    gbi_pkg::entry_t        pop_entry;
    gbi_pkg::status_t       result_status;

    assign busy = ((LVL_W + 1)'(fifo_level) + (LVL_W + 1)'(inflight)) >=
                  (LVL_W + 1)'(FIFO_DEPTH);

    gbi_front #(
        .GRID_MAX (GRID_MAX),
        .SPACING  (SPACING)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .row        (row),
        .col        (col),
        .height     (height),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .inflight   (inflight),
        .push       (push),
        .push_entry (push_entry)
    );

    gbi_fifo #(
        .WIDTH ($bits(gbi_pkg::entry_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_entry),
        .pop   (pop),
        .rdata (pop_entry),
        .empty (fifo_empty),
        .level (fifo_level)
    );

    gbi_back #(
        .SPACING (SPACING)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .empty             (fifo_empty),
        .entry             (pop_entry),
        .pop               (pop),
        .done              (done),
        .height_hundredths (height_hundredths),
        .status            (result_status)
    );

    assign status = result_status;

`ifndef SYNTH
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result did not appear at fixed latency");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != gbi_pkg::STATUS_OK)) |-> (height_hundredths == '0))
        else $error("nonzero height on error status");
`endif

endmodule

// ===== dv/tb_grid_bilinear_interpolator_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for grid_bilinear_interpolator_core: lattice writes, blended queries.
module tb_grid_bilinear_interpolator_core;

    localparam int GRID_MAX        = 320;
    localparam int SPACING         = 10;
    localparam int LAT_SIDE        = GRID_MAX / SPACING + 1;
    localparam int LAT_DEPTH       = LAT_SIDE * LAT_SIDE;
    localparam int LATENCY         = 8;
    localparam int MAX_GAP         = 18;
    localparam int RANDOM_REQUESTS = 1900;
    localparam int NUM_PHASES      = 8;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int COORD_MAX       = (1 << gbi_pkg::COORD_W) - 1;
    localparam int HEIGHT_MAX      = (1 << gbi_pkg::HEIGHT_W) - 1;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         action;
    logic [gbi_pkg::COORD_W-1:0]  row;
    logic [gbi_pkg::COORD_W-1:0]  col;
    logic [gbi_pkg::HEIGHT_W-1:0] height;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [gbi_pkg::COORD_W-1:0]  cfg_data;
    logic                         done;
    logic [gbi_pkg::RESULT_W-1:0] height_hundredths;
    logic [1:0]                   status;

    function automatic int unsigned eff_extent(input int unsigned v);
        int unsigned e;
        e = (v > GRID_MAX) ? GRID_MAX : v;
        return (e / SPACING) * SPACING;
    endfunction

    typedef struct {
        logic [gbi_pkg::RESULT_W-1:0] hundredths;
        gbi_pkg::status_t             stat;
    } blend_result_t;

    class blend_scoreboard;
        logic [gbi_pkg::HEIGHT_W-1:0] heights [LAT_DEPTH];
        int unsigned                  extent;
        blend_result_t                pending_q [$];
        int unsigned                  errors;
        int unsigned                  requests_seen;
        int unsigned                  status_count [3];

        function new();
            extent        = gbi_pkg::EXTENT_RESET;
            errors        = 0;
            requests_seen = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        function automatic longint unsigned corner(input int unsigned lr,
                                                   input int unsigned lc);
            if (lr >= LAT_SIDE || lc >= LAT_SIDE)
                return 0;
            return heights[lr * LAT_SIDE + lc];
        endfunction

        function automatic void note_request(input logic act, input int unsigned r,
                                             input int unsigned c,
                                             input logic [gbi_pkg::HEIGHT_W-1:0] h);
            blend_result_t     o;
            int unsigned       ext, fr, fc, lr0, lc0, lr1, lc1;
            longint unsigned   acc, den;
            ext = eff_extent(extent);
            o.hundredths = '0;
            o.stat = gbi_pkg::STATUS_OK;
            requests_seen++;
            if (r > ext || c > ext)
            begin
                o.stat = gbi_pkg::STATUS_BEYOND;
            end
            else if (act == gbi_pkg::ACTION_WRITE)
            begin
                if (r % SPACING != 0 || c % SPACING != 0)
                    o.stat = gbi_pkg::STATUS_OFF_LATTICE;
                else
                    heights[(r / SPACING) * LAT_SIDE + c / SPACING] = h;
            end
            else
            begin
                lr0 = r / SPACING;
                fr  = r % SPACING;
                lc0 = c / SPACING;
                fc  = c % SPACING;
                lr1 = (fr != 0) ? lr0 + 1 : lr0;
                lc1 = (fc != 0) ? lc0 + 1 : lc0;
                acc = longint'(SPACING - fr) * (SPACING - fc) * corner(lr0, lc0)
                    + longint'(SPACING - fr) * fc * corner(lr0, lc1)
                    + longint'(fr) * (SPACING - fc) * corner(lr1, lc0)
                    + longint'(fr) * fc * corner(lr1, lc1);
                den = SPACING * SPACING;
                o.hundredths = gbi_pkg::RESULT_W'((acc * gbi_pkg::HUNDRED + den / 2) / den);
            end
            pending_q.push_back(o);
        endfunction

        function automatic void check_result(input logic [gbi_pkg::RESULT_W-1:0] hh,
                                             input logic [1:0] st);
            blend_result_t exp_r;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result: height_hundredths %0d status %0d", hh, st);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            status_count[exp_r.stat]++;
            if (hh !== exp_r.hundredths)
            begin
                $error("height_hundredths: expected %0d, actual %0d", exp_r.hundredths, hh);
                errors++;
            end
            if (st !== exp_r.stat)
            begin
                $error("status: expected %0d, actual %0d", exp_r.stat, st);
                errors++;
            end
        endfunction
    endclass

    blend_scoreboard sb = new();
    bit              loaded [LAT_DEPTH];
    int unsigned     cur_extent = gbi_pkg::EXTENT_RESET;
    bit              no_idle = 1'b0;
    int unsigned     cycle_count = 0;
    int unsigned     sent_count = 0;

    grid_bilinear_interpolator_core #(
        .GRID_MAX (GRID_MAX),
        .SPACING  (SPACING)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .action            (action),
        .row               (row),
        .col               (col),
        .height            (height),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .done              (done),
        .height_hundredths (height_hundredths),
        .status            (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // results are checked before the request of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(height_hundredths, status);
            if (start && !busy)
                sb.note_request(action, row, col, height);
            if (cfg_valid && cfg_ready)
                sb.extent = cfg_data;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL grid_bilinear_interpolator_core");
            $finish;
        end
    end

    task automatic send_request(input logic act, input int unsigned r, input int unsigned c,
                                input int unsigned h);
        int unsigned gap;
        int unsigned ext;
        if ($urandom_range(0, 63) == 0)
            no_idle = !no_idle;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        action <= act;
        row    <= r[gbi_pkg::COORD_W-1:0];
        col    <= c[gbi_pkg::COORD_W-1:0];
        height <= h[gbi_pkg::HEIGHT_W-1:0];
        @(posedge clk);
        while (busy) @(posedge clk);
        sent_count++;
        ext = eff_extent(cur_extent);
        if (act == gbi_pkg::ACTION_WRITE && r <= ext && c <= ext &&
            r % SPACING == 0 && c % SPACING == 0)
            loaded[(r / SPACING) * LAT_SIDE + c / SPACING] = 1'b1;
    endtask

    // write any corner a query would blend that holds no height yet, then query
    task automatic query_at(input int unsigned r, input int unsigned c);
        int unsigned ext;
        int unsigned lr [2];
        int unsigned lc [2];
        ext = eff_extent(cur_extent);
        if (r <= ext && c <= ext)
        begin
            lr[0] = r / SPACING;
            lr[1] = lr[0] + ((r % SPACING != 0) ? 1 : 0);
            lc[0] = c / SPACING;
            lc[1] = lc[0] + ((c % SPACING != 0) ? 1 : 0);
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2; j++)
                    if (!loaded[lr[i] * LAT_SIDE + lc[j]])
                        send_request(gbi_pkg::ACTION_WRITE, lr[i] * SPACING, lc[j] * SPACING,
                                     $urandom_range(0, HEIGHT_MAX));
        end
        send_request(gbi_pkg::ACTION_QUERY, r, c, $urandom_range(0, HEIGHT_MAX));
    endtask

    task automatic set_extent(input int unsigned v);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v[gbi_pkg::COORD_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid  <= 1'b0;
        cur_extent = v;
    endtask

    // runs until n more requests, corner preloads included, have been accepted
    task automatic random_phase(input int unsigned n);
        int unsigned ext, pick, r, c, tmp, phase_end;
        phase_end = sent_count + n;
        while (sent_count < phase_end)
        begin
            ext  = eff_extent(cur_extent);
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                r = $urandom_range(0, ext);
                c = $urandom_range(0, ext);
                if ($urandom_range(0, 3) == 0) r = (r / SPACING) * SPACING;
                if ($urandom_range(0, 3) == 0) c = (c / SPACING) * SPACING;
                if ($urandom_range(0, 15) == 0) r = ext;
                if ($urandom_range(0, 15) == 0) c = ext;
                query_at(r, c);
            end
            else if (pick < 75)
            begin
                send_request(gbi_pkg::ACTION_WRITE, $urandom_range(0, ext / SPACING) * SPACING,
                             $urandom_range(0, ext / SPACING) * SPACING,
                             $urandom_range(0, HEIGHT_MAX));
            end
            else if (pick < 85 && ext >= SPACING)
            begin
                r = $urandom_range(0, ext / SPACING - 1) * SPACING +
                    $urandom_range(1, SPACING - 1);
                c = $urandom_range(0, ext);
                if ($urandom_range(0, 1) == 1)
                begin
                    tmp = r;
                    r   = c;
                    c   = tmp;
                end
                send_request(gbi_pkg::ACTION_WRITE, r, c, $urandom_range(0, HEIGHT_MAX));
            end
            else
            begin
                r = $urandom_range(0, COORD_MAX);
                c = $urandom_range(0, COORD_MAX);
                if ($urandom_range(0, 1) == 1)
                    query_at(r, c);
                else
                    send_request(gbi_pkg::ACTION_WRITE, r, c, $urandom_range(0, HEIGHT_MAX));
            end
        end
    endtask

    initial
    begin
        int unsigned phase_extent [NUM_PHASES];
        rst_n     = 1'b0;
        start     = 1'b0;
        action    = gbi_pkg::ACTION_WRITE;
        row       = '0;
        col       = '0;
        height    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        phase_extent = '{320, 0, 10, 511, 155, 327, 60, 320};
        phase_extent[NUM_PHASES-1] = $urandom_range(SPACING, GRID_MAX);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_extent(GRID_MAX);
        send_request(gbi_pkg::ACTION_WRITE, 0, 0, HEIGHT_MAX);
        send_request(gbi_pkg::ACTION_WRITE, 0, SPACING, 0);
        send_request(gbi_pkg::ACTION_WRITE, SPACING, 0, 512);
        send_request(gbi_pkg::ACTION_WRITE, SPACING, SPACING, 1);
        query_at(0, 0);
        query_at(5, 5);
        query_at(0, 5);
        query_at(5, 0);
        query_at(9, 9);
        send_request(gbi_pkg::ACTION_WRITE, GRID_MAX, GRID_MAX, HEIGHT_MAX);
        query_at(GRID_MAX, GRID_MAX);
        send_request(gbi_pkg::ACTION_WRITE, 5, SPACING, 77);
        send_request(gbi_pkg::ACTION_WRITE, SPACING, 3, 77);
        send_request(gbi_pkg::ACTION_WRITE, GRID_MAX + 1, 0, 300);
        query_at(0, GRID_MAX + 1);
        send_request(gbi_pkg::ACTION_WRITE, COORD_MAX, COORD_MAX, HEIGHT_MAX);
        query_at(COORD_MAX, 0);
        send_request(gbi_pkg::ACTION_WRITE, GRID_MAX + 5, 7, 9);
        send_request(gbi_pkg::ACTION_WRITE, GRID_MAX - SPACING, GRID_MAX - SPACING, 1000);
        send_request(gbi_pkg::ACTION_WRITE, GRID_MAX - SPACING, GRID_MAX, 3);
        send_request(gbi_pkg::ACTION_WRITE, GRID_MAX, GRID_MAX - SPACING, 511);
        query_at(GRID_MAX - 5, GRID_MAX - 5);
        query_at(GRID_MAX, GRID_MAX - 5);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_extent(phase_extent[p]);
            random_phase(RANDOM_REQUESTS / NUM_PHASES);
        end

        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        $display("Checked %0d requests over %0d extent settings, extents 0 through %0d.",
                 sb.requests_seen, NUM_PHASES + 1, COORD_MAX);
        $display("Results: %0d ok, %0d off-lattice writes, %0d beyond extent, %0d errors.",
                 sb.status_count[gbi_pkg::STATUS_OK],
                 sb.status_count[gbi_pkg::STATUS_OFF_LATTICE],
                 sb.status_count[gbi_pkg::STATUS_BEYOND], sb.errors);
        if (sb.errors == 0)
            $display("PASS grid_bilinear_interpolator_core");
        else
            $display("FAIL grid_bilinear_interpolator_core");
        $finish;
    end

endmodule
